### hw/rtl/kalman_cv_position_filter_top_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef KALMAN_CV_POSITION_FILTER_TOP_ASSERT_SVH
`define KALMAN_CV_POSITION_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define KCV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kcv assertion failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define KCV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kcv assertion failed");

`endif

### hw/rtl/kcv_pkg.sv
// Package with types, constants and the operation program of the filter.
`timescale 1ns / 1ps
`default_nettype none

package kcv_pkg;

    localparam int DATA_W    = 32;
    localparam int VAR_W     = 31;
    localparam int MEM_AW    = 6;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int ACC_W     = 50;
    localparam int PC_W      = 8;
    localparam int PROG_LEN  = 1 << PC_W;
    localparam int DT_W      = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [DT_W-1:0]   MAX_DT  = 17'h1_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_START_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VAR_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VAR_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 3'd5;

    localparam int A_E     = 0;
    localparam int A_P     = 4;
    localparam int A_T     = 20;
    localparam int A_K     = 28;
    localparam int A_M     = 36;
    localparam int A_SI    = 44;
    localparam int A_S00   = 48;
    localparam int A_S11   = 49;
    localparam int A_ADJ01 = 50;
    localparam int A_ADJ10 = 51;
    localparam int A_IN0   = 52;
    localparam int A_IN1   = 53;
    localparam int A_DET   = 54;

    localparam int INIT_BASE = 0;
    localparam int MAIN_BASE = 20;

    typedef logic [MEM_AW-1:0] t_addr;

    typedef enum logic [2:0] {
        K_ADDA,
        K_SUBA,
        K_ADDB,
        K_MUL,
        K_MULN,
        K_DIV,
        K_CHK
    } t_kind;

    typedef enum logic [3:0] {
        B_MEM,
        B_DT,
        B_Q,
        B_R,
        B_ZX,
        B_ZY,
        B_ONE,
        B_SPX,
        B_SPY,
        B_SVX,
        B_SVY,
        B_ZERO
    } t_bsel;

    typedef struct packed {
        t_kind kind;
        logic  clr;
        logic  wr;
        logic  last;
        t_addr a;
        t_addr b;
        t_bsel bsel;
        t_addr dst;
    } t_op;

    typedef t_op [PROG_LEN-1:0] t_prog;

    function automatic t_addr ad(int v);
        return t_addr'(v);
    endfunction

    function automatic t_addr pa(int i, int j);
        return t_addr'(A_P + 4 * i + j);
    endfunction

    function automatic t_addr ta(int i, int j);
        return t_addr'(A_T + 4 * i + j);
    endfunction

    function automatic t_addr ka(int i, int j);
        return t_addr'(A_K + 2 * i + j);
    endfunction

    function automatic t_addr ma(int i, int j);
        return t_addr'(A_M + 2 * i + j);
    endfunction

    function automatic t_addr sa(int i, int j);
        return t_addr'(A_SI + 2 * i + j);
    endfunction

    function automatic t_op mk(t_kind kind, logic clr, logic wr, t_addr a, t_addr b,
                               t_bsel bsel, t_addr dst);
        t_op op;
        op.kind = kind;
        op.clr  = clr;
        op.wr   = wr;
        op.last = 1'b0;
        op.a    = a;
        op.b    = b;
        op.bsel = bsel;
        op.dst  = dst;
        return op;
    endfunction

    function automatic t_prog build_prog();
        t_prog p;
        int    n;
        int    i;
        int    j;
        t_addr z;
        t_addr s;
        t_bsel bs;
        p = '0;
        z = '0;
        n = INIT_BASE;
        for (i = 0; i < 4; i++) begin
            bs = B_ZERO;
            if (i == 0) bs = B_SPX;
            if (i == 1) bs = B_SPY;
            p[n] = mk(K_ADDB, 1'b1, 1'b1, z, z, bs, ad(A_E + i)); n++;
        end
        for (i = 0; i < 4; i++) begin
            for (j = 0; j < 4; j++) begin
                bs = B_ZERO;
                if (i == j) bs = B_ONE;
                if (i == j && i == 0) bs = B_SVX;
                if (i == j && i == 1) bs = B_SVY;
                p[n] = mk(K_ADDB, 1'b1, 1'b1, z, z, bs, pa(i, j)); n++;
            end
        end
        p[n - 1].last = 1'b1;

        n = MAIN_BASE;
        for (i = 0; i < 2; i++) begin
            p[n] = mk(K_ADDA, 1'b1, 1'b0, ad(A_E + i), z, B_MEM, z); n++;
            p[n] = mk(K_MUL, 1'b0, 1'b1, ad(A_E + i + 2), z, B_DT, ad(A_E + i)); n++;
        end
        for (i = 0; i < 2; i++) begin
            for (j = 0; j < 4; j++) begin
                p[n] = mk(K_ADDA, 1'b1, 1'b0, pa(i, j), z, B_MEM, z); n++;
                p[n] = mk(K_MUL, 1'b0, 1'b1, pa(i + 2, j), z, B_DT, ta(i, j)); n++;
            end
        end
        for (i = 0; i < 4; i++) begin
            for (j = 0; j < 4; j++) begin
                if (j < 2) begin
                    s = (i < 2) ? ta(i, j) : pa(i, j);
                    p[n] = mk(K_ADDA, 1'b1, 1'b0, s, z, B_MEM, z); n++;
                    s = (i < 2) ? ta(i, j + 2) : pa(i, j + 2);
                    p[n] = mk(K_MUL, 1'b0, 1'b1, s, z, B_DT, pa(i, j)); n++;
                end else if (i < 2) begin
                    p[n] = mk(K_ADDA, 1'b1, 1'b1, ta(i, j), z, B_MEM, pa(i, j)); n++;
                end
            end
        end
        for (i = 0; i < 4; i++) begin
            p[n] = mk(K_ADDA, 1'b1, 1'b0, pa(i, i), z, B_MEM, z); n++;
            p[n] = mk(K_ADDB, 1'b0, 1'b1, z, z, B_Q, pa(i, i)); n++;
        end
        p[n] = mk(K_ADDB, 1'b1, 1'b0, z, z, B_ZX, z); n++;
        p[n] = mk(K_SUBA, 1'b0, 1'b1, ad(A_E), z, B_MEM, ad(A_IN0)); n++;
        p[n] = mk(K_ADDB, 1'b1, 1'b0, z, z, B_ZY, z); n++;
        p[n] = mk(K_SUBA, 1'b0, 1'b1, ad(A_E + 1), z, B_MEM, ad(A_IN1)); n++;
        p[n] = mk(K_ADDA, 1'b1, 1'b0, pa(0, 0), z, B_MEM, z); n++;
        p[n] = mk(K_ADDB, 1'b0, 1'b1, z, z, B_R, ad(A_S00)); n++;
        p[n] = mk(K_ADDA, 1'b1, 1'b0, pa(1, 1), z, B_MEM, z); n++;
        p[n] = mk(K_ADDB, 1'b0, 1'b1, z, z, B_R, ad(A_S11)); n++;
        p[n] = mk(K_MUL, 1'b1, 1'b0, ad(A_S00), ad(A_S11), B_MEM, z); n++;
        p[n] = mk(K_MULN, 1'b0, 1'b1, pa(0, 1), pa(1, 0), B_MEM, ad(A_DET)); n++;
        p[n] = mk(K_CHK, 1'b0, 1'b0, z, z, B_MEM, z); n++;
        p[n] = mk(K_SUBA, 1'b1, 1'b1, pa(0, 1), z, B_MEM, ad(A_ADJ01)); n++;
        p[n] = mk(K_SUBA, 1'b1, 1'b1, pa(1, 0), z, B_MEM, ad(A_ADJ10)); n++;
        p[n] = mk(K_DIV, 1'b0, 1'b1, ad(A_S11), ad(A_DET), B_MEM, sa(0, 0)); n++;
        p[n] = mk(K_DIV, 1'b0, 1'b1, ad(A_ADJ01), ad(A_DET), B_MEM, sa(0, 1)); n++;
        p[n] = mk(K_DIV, 1'b0, 1'b1, ad(A_ADJ10), ad(A_DET), B_MEM, sa(1, 0)); n++;
        p[n] = mk(K_DIV, 1'b0, 1'b1, ad(A_S00), ad(A_DET), B_MEM, sa(1, 1)); n++;
        for (i = 0; i < 4; i++) begin
            for (j = 0; j < 2; j++) begin
                p[n] = mk(K_MUL, 1'b1, 1'b0, pa(i, 0), sa(0, j), B_MEM, z); n++;
                p[n] = mk(K_MUL, 1'b0, 1'b1, pa(i, 1), sa(1, j), B_MEM, ka(i, j)); n++;
            end
        end
        for (i = 0; i < 4; i++) begin
            p[n] = mk(K_ADDA, 1'b1, 1'b0, ad(A_E + i), z, B_MEM, z); n++;
            p[n] = mk(K_MUL, 1'b0, 1'b0, ka(i, 0), ad(A_IN0), B_MEM, z); n++;
            p[n] = mk(K_MUL, 1'b0, 1'b1, ka(i, 1), ad(A_IN1), B_MEM, ad(A_E + i)); n++;
        end
        for (i = 0; i < 4; i++) begin
            for (j = 0; j < 2; j++) begin
                if (i == j) begin
                    p[n] = mk(K_ADDB, 1'b1, 1'b0, z, z, B_ONE, z); n++;
                    p[n] = mk(K_SUBA, 1'b0, 1'b1, ka(i, j), z, B_MEM, ma(i, j)); n++;
                end else begin
                    p[n] = mk(K_SUBA, 1'b1, 1'b1, ka(i, j), z, B_MEM, ma(i, j)); n++;
                end
            end
        end
        for (i = 2; i < 4; i++) begin
            for (j = 0; j < 4; j++) begin
                p[n] = mk(K_ADDA, 1'b1, 1'b0, pa(i, j), z, B_MEM, z); n++;
                p[n] = mk(K_MUL, 1'b0, 1'b0, ma(i, 0), pa(0, j), B_MEM, z); n++;
                p[n] = mk(K_MUL, 1'b0, 1'b1, ma(i, 1), pa(1, j), B_MEM, pa(i, j)); n++;
            end
        end
        for (j = 0; j < 4; j++) begin
            p[n] = mk(K_MUL, 1'b1, 1'b0, ma(0, 0), pa(0, j), B_MEM, z); n++;
            p[n] = mk(K_MUL, 1'b0, 1'b1, ma(0, 1), pa(1, j), B_MEM, ta(0, j)); n++;
        end
        for (j = 0; j < 4; j++) begin
            p[n] = mk(K_MUL, 1'b1, 1'b0, ma(1, 0), pa(0, j), B_MEM, z); n++;
            p[n] = mk(K_MUL, 1'b0, 1'b1, ma(1, 1), pa(1, j), B_MEM, pa(1, j)); n++;
        end
        for (j = 0; j < 4; j++) begin
            p[n] = mk(K_ADDA, 1'b1, 1'b1, ta(0, j), z, B_MEM, pa(0, j)); n++;
        end
        p[n - 1].last = 1'b1;
        return p;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/kcv_div.sv
// Restoring divider for the inverse of the innovation covariance, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module kcv_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kcv_pkg::DATA_W-1:0]  i_num,
    input  logic [kcv_pkg::VAR_W-1:0]   i_den,
    output logic                        o_done,
    output logic [kcv_pkg::DATA_W-1:0]  o_quo
);
    import kcv_pkg::*;

    localparam int QUO_W = DATA_W + 16;
    localparam int CNT_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [VAR_W-1:0]  r_den;
    logic [VAR_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;

    logic [DATA_W-1:0] w_mag;
    logic [DATA_W-1:0] w_trial;
    logic [DATA_W-1:0] w_diff;
    logic              w_ge;
    logic [DATA_W-1:0] w_neg_q;

    assign w_mag   = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_neg_q = ~r_quo[DATA_W-1:0] + 1'b1;

    always_comb begin
        if (r_neg) begin
            if (r_quo > QUO_W'(33'h1_0000_0000 >> 1)) begin
                o_quo = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                o_quo = w_neg_q;
            end
        end else begin
            if (r_quo > QUO_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
                o_quo = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                o_quo = r_quo[DATA_W-1:0];
            end
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[DATA_W-1];
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= {w_mag, 16'h0000};
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[VAR_W-1:0] : w_trial[VAR_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kalman_cv_position_filter_top.sv
// Top level of the constant-velocity Kalman position filter with its operation sequencer.
// Usage: one input item per transfer carries a timestamp and a measured x,y position.
// An item is transferred when i_valid is high and o_stall is low; o_stall stays high
// from the transfer until the item is finished, so one item is worked on at a time.
// The first item after reset loads the start estimate and covariance from the
// configuration registers and gives no result.
// An item whose time step is zero or above one second is dropped.
// A filtered item runs 147 operations. All but the determinant check and the four
// divisions go through one shared multiply-accumulate unit, each as a read, execute
// and accumulate step; the divisions run in the bit-serial divider. If the
// determinant of the innovation covariance is not positive the update is skipped
// and the predicted estimate is the result.
// The result sits in an output register until the receiver takes it (o_valid high,
// i_stall low); while it waits the block already takes the next item, and stalls
// only if a second result is ready before the first has been taken.
// Reset clears the time history, so the next item loads the start values again.
// Configuration writes are taken at any time but must only be made while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "kalman_cv_position_filter_top_assert.svh"

module kalman_cv_position_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [kcv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kcv_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [kcv_pkg::DATA_W-1:0]        i_timestamp,
    input  logic signed [kcv_pkg::DATA_W-1:0] i_meas_x,
    input  logic signed [kcv_pkg::DATA_W-1:0] i_meas_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [kcv_pkg::DATA_W-1:0] o_est_x,
    output logic signed [kcv_pkg::DATA_W-1:0] o_est_y,
    output logic signed [kcv_pkg::DATA_W-1:0] o_est_vx,
    output logic signed [kcv_pkg::DATA_W-1:0] o_est_vy,
    output logic [kcv_pkg::VAR_W-1:0]         o_var_x,
    output logic [kcv_pkg::VAR_W-1:0]         o_var_y
);
    import kcv_pkg::*;

    localparam t_prog PROG = build_prog();
    localparam logic [PC_W-1:0] INIT_PC = PC_W'(INIT_BASE);
    localparam logic [PC_W-1:0] MAIN_PC = PC_W'(MAIN_BASE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_AC,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [PC_W-1:0]     r_pc;
    logic                r_emit;
    logic                r_time_valid;
    logic [DATA_W-1:0]   r_last_time;
    logic [DT_W-1:0]     r_dt;
    logic [DATA_W-1:0]   r_zx;
    logic [DATA_W-1:0]   r_zy;
    logic                r_det_pos;
    logic [ACC_W-1:0]    r_acc;
    logic signed [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0]   r_rda;
    logic [DATA_W-1:0]   r_rdb;
    logic [DATA_W-1:0]   r_mem [MEM_DEPTH];
    logic [DATA_W-1:0]   r_sh_e [4];
    logic [DATA_W-1:0]   r_sh_vx;
    logic [DATA_W-1:0]   r_sh_vy;

    logic [DATA_W-1:0]   r_spx;
    logic [DATA_W-1:0]   r_spy;
    logic [VAR_W-1:0]    r_svx;
    logic [VAR_W-1:0]    r_svy;
    logic [VAR_W-1:0]    r_q;
    logic [VAR_W-1:0]    r_r;

    logic                r_o_valid;
    logic [DATA_W-1:0]   r_o_x;
    logic [DATA_W-1:0]   r_o_y;
    logic [DATA_W-1:0]   r_o_vx;
    logic [DATA_W-1:0]   r_o_vy;
    logic [VAR_W-1:0]    r_o_var_x;
    logic [VAR_W-1:0]    r_o_var_y;

    t_op                 w_op;
    logic [DATA_W-1:0]   w_dt;
    logic [DATA_W-1:0]   w_bval;
    logic signed [2*DATA_W-1:0] w_prod;
    logic [ACC_W-1:0]    w_base;
    logic [ACC_W-1:0]    w_term;
    logic [ACC_W-1:0]    w_acc_new;
    logic [DATA_W-1:0]   w_sat;
    logic                w_we;
    logic [DATA_W-1:0]   w_wdata;
    logic                w_div_start;
    logic                w_div_done;
    logic [DATA_W-1:0]   w_div_q;
    logic                w_out_free;
    logic                w_out_load;
    logic                w_init_xfer;

    assign w_op        = PROG[r_pc];
    assign o_stall     = (r_state != S_IDLE);
    assign w_dt        = i_timestamp - r_last_time;
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_out_load  = (r_state == S_OUT) && w_out_free;
    assign w_init_xfer = (r_state == S_IDLE) && i_valid && !r_time_valid;

    always_comb begin
        unique case (w_op.bsel)
            B_MEM:   w_bval = r_rdb;
            B_DT:    w_bval = {{(DATA_W-DT_W){1'b0}}, r_dt};
            B_Q:     w_bval = {1'b0, r_q};
            B_R:     w_bval = {1'b0, r_r};
            B_ZX:    w_bval = r_zx;
            B_ZY:    w_bval = r_zy;
            B_ONE:   w_bval = ONE_Q16;
            B_SPX:   w_bval = r_spx;
            B_SPY:   w_bval = r_spy;
            B_SVX:   w_bval = {1'b0, r_svx};
            B_SVY:   w_bval = {1'b0, r_svy};
            B_ZERO:  w_bval = '0;
            default: w_bval = '0;
        endcase
    end

    assign w_prod = $signed(r_rda) * $signed(w_bval);
    assign w_base = w_op.clr ? '0 : r_acc;

    always_comb begin
        unique case (w_op.kind)
            K_ADDA:  w_term = {{(ACC_W-DATA_W){r_rda[DATA_W-1]}}, r_rda};
            K_SUBA:  w_term = ~{{(ACC_W-DATA_W){r_rda[DATA_W-1]}}, r_rda} + 1'b1;
            K_ADDB:  w_term = {{(ACC_W-DATA_W){w_bval[DATA_W-1]}}, w_bval};
            K_MUL:   w_term = {{(ACC_W-2*DATA_W+16){r_prod[2*DATA_W-1]}},
                               r_prod[2*DATA_W-1:16]};
            K_MULN:  w_term = ~{{(ACC_W-2*DATA_W+16){r_prod[2*DATA_W-1]}},
                                r_prod[2*DATA_W-1:16]} + 1'b1;
            default: w_term = '0;
        endcase
    end

    assign w_acc_new = w_base + w_term;

    always_comb begin
        if ((&w_acc_new[ACC_W-1:DATA_W-1]) || !(|w_acc_new[ACC_W-1:DATA_W-1])) begin
            w_sat = w_acc_new[DATA_W-1:0];
        end else if (w_acc_new[ACC_W-1]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign w_div_start = (r_state == S_EX) && (w_op.kind == K_DIV);
    assign w_we        = ((r_state == S_AC) && w_op.wr) || ((r_state == S_DIV) && w_div_done);
    assign w_wdata     = (r_state == S_DIV) ? w_div_q : w_sat;

    kcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_rda),
        .i_den   (r_rdb[VAR_W-1:0]),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_op.dst] <= w_wdata;
            for (int k = 0; k < 4; k++) begin
                if (w_op.dst == ad(A_E + k)) begin
                    r_sh_e[k] <= w_wdata;
                end
            end
            if (w_op.dst == pa(0, 0)) begin
                r_sh_vx <= w_wdata;
            end
            if (w_op.dst == pa(1, 1)) begin
                r_sh_vy <= w_wdata;
            end
        end
        if (r_state == S_RD) begin
            r_rda <= r_mem[w_op.a];
            r_rdb <= r_mem[w_op.b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pc         <= '0;
            r_emit       <= 1'b0;
            r_time_valid <= 1'b0;
            r_last_time  <= '0;
            r_det_pos    <= 1'b0;
            r_o_valid    <= 1'b0;
            r_spx        <= '0;
            r_spy        <= '0;
            r_svx        <= VAR_W'(32768);
            r_svy        <= VAR_W'(32768);
            r_q          <= VAR_W'(655);
            r_r          <= VAR_W'(3277);
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_START_POS_X: r_spx <= i_cfg_data;
                    CFG_START_POS_Y: r_spy <= i_cfg_data;
                    CFG_START_VAR_X: r_svx <= i_cfg_data[VAR_W-1:0];
                    CFG_START_VAR_Y: r_svy <= i_cfg_data[VAR_W-1:0];
                    CFG_PROC_NOISE:  r_q   <= i_cfg_data[VAR_W-1:0];
                    CFG_MEAS_NOISE:  r_r   <= i_cfg_data[VAR_W-1:0];
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (w_we && (w_op.dst == ad(A_DET))) begin
                r_det_pos <= !w_wdata[DATA_W-1] && (|w_wdata);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last_time <= i_timestamp;
                        r_zx        <= i_meas_x;
                        r_zy        <= i_meas_y;
                        r_dt        <= w_dt[DT_W-1:0];
                        if (!r_time_valid) begin
                            r_time_valid <= 1'b1;
                            r_pc         <= INIT_PC;
                            r_emit       <= 1'b0;
                            r_state      <= S_RD;
                        end else if ((w_dt != '0) && (w_dt <= DATA_W'(MAX_DT))) begin
                            r_pc    <= MAIN_PC;
                            r_emit  <= 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (w_op.kind == K_CHK) begin
                        if (r_det_pos) begin
                            r_pc <= r_pc + 1'b1;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_EX;
                    end
                end
                S_EX: begin
                    r_prod <= w_prod;
                    if (w_op.kind == K_DIV) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_AC;
                    end
                end
                S_AC: begin
                    r_acc <= w_acc_new;
                    if (w_op.last) begin
                        r_state <= r_emit ? S_OUT : S_IDLE;
                    end else begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_x     <= r_sh_e[0];
                        r_o_y     <= r_sh_e[1];
                        r_o_vx    <= r_sh_e[2];
                        r_o_vy    <= r_sh_e[3];
                        r_o_var_x <= r_sh_vx[DATA_W-1] ? '0 : r_sh_vx[VAR_W-1:0];
                        r_o_var_y <= r_sh_vy[DATA_W-1] ? '0 : r_sh_vy[VAR_W-1:0];
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_o_valid;
    assign o_est_x  = r_o_x;
    assign o_est_y  = r_o_y;
    assign o_est_vx = r_o_vx;
    assign o_est_vy = r_o_vy;
    assign o_var_x  = r_o_var_x;
    assign o_var_y  = r_o_var_y;

    `KCV_ASSERT_IMP(a_div_done_in_div, w_div_done, r_state == S_DIV)
    `KCV_ASSERT_IMP(a_write_only_busy, w_we, (r_state == S_AC) || (r_state == S_DIV))
    `KCV_ASSERT_NXT(a_first_item_init, w_init_xfer, (r_state == S_RD) && (r_pc == INIT_PC))

endmodule

`default_nettype wire

### tb/kalman_cv_position_filter_top_tb.sv
// Self-checking testbench for the constant-velocity Kalman position filter.
`timescale 1ns / 1ps

module kalman_cv_position_filter_top_tb;
    import kcv_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 800;
    localparam int          RANDOM_PER_PHASE = 475;
    localparam int          Q16_ONE = 65536;
    localparam int unsigned MAX_STEP = 65536;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef int t_mat4[4][4];

    typedef struct {
        int        x;
        int        y;
        int        vx;
        int        vy;
        bit [30:0] vxx;
        bit [30:0] vyy;
    } t_estimate;

    typedef struct {
        int unsigned ts;
        int          mx;
        int          my;
        bit          silent;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [DATA_W-1:0]       i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [DATA_W-1:0]       i_timestamp;
    logic signed [DATA_W-1:0] i_meas_x;
    logic signed [DATA_W-1:0] i_meas_y;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [DATA_W-1:0] o_est_x;
    logic signed [DATA_W-1:0] o_est_y;
    logic signed [DATA_W-1:0] o_est_vx;
    logic signed [DATA_W-1:0] o_est_vy;
    logic [VAR_W-1:0]        o_var_x;
    logic [VAR_W-1:0]        o_var_y;

    kalman_cv_position_filter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_timestamp (i_timestamp),
        .i_meas_x    (i_meas_x),
        .i_meas_y    (i_meas_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_est_x     (o_est_x),
        .o_est_y     (o_est_y),
        .o_est_vx    (o_est_vx),
        .o_est_vy    (o_est_vy),
        .o_var_x     (o_var_x),
        .o_var_y     (o_var_y)
    );

    int          cfg_pos_x, cfg_pos_y, cfg_var_x, cfg_var_y, cfg_q, cfg_r;
    int          state_est[4];
    t_mat4       state_cov;
    int unsigned prev_ts;
    bit          have_ts;

    t_estimate   pending_estimates[$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned next_ts;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic t_mat4 mat_mul(t_mat4 a, t_mat4 b);
        t_mat4  c;
        longint acc;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += qmul(a[i][k], b[k][j]);
                c[i][j] = clip32(acc);
            end
        end
        return c;
    endfunction

    function automatic bit [30:0] var_out(int v);
        return (v < 0) ? 31'd0 : v[30:0];
    endfunction

    function automatic bit filter_step(int unsigned ts, int zx, int zy, output t_estimate res);
        t_mat4       f, ft, m;
        int          nx[4];
        int          s[2][2], si[2][2], adj[2][2], gain[4][2], innov[2];
        int unsigned dt;
        longint      acc, det;
        res = '{default: 0};
        if (!have_ts) begin
            state_cov = '{default: '{default: 0}};
            state_est = '{cfg_pos_x, cfg_pos_y, 0, 0};
            state_cov[0][0] = cfg_var_x;
            state_cov[1][1] = cfg_var_y;
            state_cov[2][2] = Q16_ONE;
            state_cov[3][3] = Q16_ONE;
            prev_ts = ts;
            have_ts = 1'b1;
            return 1'b0;
        end
        dt = ts - prev_ts;
        prev_ts = ts;
        if (dt == 0 || dt > MAX_STEP) return 1'b0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) f[i][j] = (i == j) ? Q16_ONE : 0;
        f[0][2] = int'(dt);
        f[1][3] = int'(dt);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) ft[i][j] = f[j][i];
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) acc += qmul(f[i][c], state_est[c]);
            nx[i] = clip32(acc);
        end
        state_est = nx;
        state_cov = mat_mul(mat_mul(f, state_cov), ft);
        for (int i = 0; i < 4; i++)
            state_cov[i][i] = clip32(longint'(state_cov[i][i]) + cfg_q);
        innov[0] = clip32(longint'(zx) - state_est[0]);
        innov[1] = clip32(longint'(zy) - state_est[1]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) s[i][j] = state_cov[i][j];
        s[0][0] = clip32(longint'(s[0][0]) + cfg_r);
        s[1][1] = clip32(longint'(s[1][1]) + cfg_r);
        det = clip32(qmul(s[0][0], s[1][1]) - qmul(s[0][1], s[1][0]));
        if (det > 0) begin
            adj[0][0] = s[1][1];
            adj[0][1] = clip32(-longint'(s[0][1]));
            adj[1][0] = clip32(-longint'(s[1][0]));
            adj[1][1] = s[0][0];
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    si[i][j] = clip32((longint'(adj[i][j]) * Q16_ONE) / det);
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 2; j++)
                    gain[i][j] = clip32(qmul(state_cov[i][0], si[0][j]) +
                                        qmul(state_cov[i][1], si[1][j]));
            for (int i = 0; i < 4; i++)
                state_est[i] = clip32(longint'(state_est[i]) + qmul(gain[i][0], innov[0]) +
                                      qmul(gain[i][1], innov[1]));
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    m[i][j] = clip32(((i == j) ? longint'(Q16_ONE) : 0) -
                                     ((j < 2) ? longint'(gain[i][j]) : 0));
            state_cov = mat_mul(m, state_cov);
        end
        res.x   = state_est[0];
        res.y   = state_est[1];
        res.vx  = state_est[2];
        res.vy  = state_est[3];
        res.vxx = var_out(state_cov[0][0]);
        res.vyy = var_out(state_cov[1][1]);
        return 1'b1;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_START_POS_X: cfg_pos_x = int'(data);
            CFG_START_POS_Y: cfg_pos_y = int'(data);
            CFG_START_VAR_X: cfg_var_x = int'({1'b0, data[30:0]});
            CFG_START_VAR_Y: cfg_var_y = int'({1'b0, data[30:0]});
            CFG_PROC_NOISE:  cfg_q     = int'({1'b0, data[30:0]});
            CFG_MEAS_NOISE:  cfg_r     = int'({1'b0, data[30:0]});
            default: ;
        endcase
    endtask

    // Drives one measurement, waits for its transfer and books the expected estimate if it gives one.
    task automatic send_measurement(int unsigned ts, int mx, int my, output bit produced);
        t_estimate res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_timestamp <= ts;
        i_meas_x    <= mx;
        i_meas_y    <= my;
        do @(posedge i_clk); while (o_stall);
        produced = filter_step(ts, mx, my, res);
        if (produced) pending_estimates.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        int unsigned dt;
        int          mx, my, pick;
        bit          produced;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 4) dt = 0;
            else if (pick < 8) dt = $urandom_range(32'hffffffff, MAX_STEP + 1);
            else if (pick < 12) dt = MAX_STEP;
            else if (pick < 30) dt = $urandom_range(64, 1);
            else dt = $urandom_range(MAX_STEP, 1);
            next_ts += dt;
            pick = $urandom_range(99);
            if (pick < 8) begin
                mx = $urandom();
                my = $urandom();
            end else begin
                mx = clip32(longint'(state_est[0]) + $signed($urandom_range(1 << 20)) - (1 << 19));
                my = clip32(longint'(state_est[1]) + $signed($urandom_range(1 << 20)) - (1 << 19));
            end
            send_measurement(next_ts, mx, my, produced);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_estimate want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_estimates.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, o_est_x, o_est_y);
                errors++;
            end else begin
                want = pending_estimates.pop_front();
                if (o_est_x !== want.x || o_est_y !== want.y || o_est_vx !== want.vx ||
                    o_est_vy !== want.vy || o_var_x !== want.vxx || o_var_y !== want.vyy) begin
                    $display("%0t: mismatch expected x=%0d y=%0d vx=%0d vy=%0d vx2=%0d vy2=%0d",
                             $time, want.x, want.y, want.vx, want.vy, want.vxx, want.vyy);
                    $display("%0t:          actual   x=%0d y=%0d vx=%0d vy=%0d vx2=%0d vy2=%0d",
                             $time, o_est_x, o_est_y, o_est_vx, o_est_vy, o_var_x, o_var_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        bit   produced;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 12;
        recv_idle_pct = 45;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_timestamp = '0;
        i_meas_x = '0;
        i_meas_y = '0;
        cfg_pos_x = 0;
        cfg_pos_y = 0;
        cfg_var_x = 32768;
        cfg_var_y = 32768;
        cfg_q = 655;
        cfg_r = 3277;
        state_est = '{default: 0};
        state_cov = '{default: '{default: 0}};
        prev_ts = 0;
        have_ts = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme start values and the smallest nonzero measurement noise drive the saturation paths.
        write_reg(CFG_START_POS_X, 32'h7fff_ffff);
        write_reg(CFG_START_POS_Y, 32'h8000_0000);
        write_reg(CFG_START_VAR_X, 32'h0000_0000);
        write_reg(CFG_START_VAR_Y, 32'hffff_ffff);
        write_reg(CFG_PROC_NOISE, 32'h0000_0000);
        write_reg(CFG_MEAS_NOISE, 32'h0000_0001);
        write_reg(CFG_UNUSED, 32'hdead_beef);

        rows = '{
            '{32'hffff_fff0, 32'h7fff_ffff, 32'h8000_0000, 1'b1},
            '{32'hffff_fff0, 0, 0, 1'b1},
            '{32'h0000_0001, 0, 0, 1'b0},
            '{32'h0000_0002, 32'h7fff_ffff, 32'h8000_0000, 1'b0},
            '{32'h0001_0002, 32'h8000_0000, 32'h7fff_ffff, 1'b0},
            '{32'h0002_0003, 0, 0, 1'b1},
            '{32'h0002_0003, 0, 0, 1'b1},
            '{32'h0002_0002, 0, 0, 1'b1},
            '{32'h0003_0002, 32'h0001_0000, 32'hffff_0000, 1'b0},
            '{32'h0003_0003, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0},
            '{32'h0003_8003, 32'h8000_0000, 32'h8000_0000, 1'b0},
            '{32'h0004_8003, 32'h5555_5555, 32'haaaa_aaaa, 1'b0},
            '{32'h0005_8003, 32'haaaa_aaaa, 32'h5555_5555, 1'b0},
            '{32'h0005_8004, 0, 0, 1'b0},
            '{32'hffff_ffff, 0, 0, 1'b1},
            '{32'h0000_0000, 32'h0000_1000, 32'h0000_2000, 1'b0}
        };
        foreach (rows[n]) begin
            send_measurement(rows[n].ts, rows[n].mx, rows[n].my, produced);
            if (rows[n].silent && produced) begin
                $display("%0t: expected no result for row %0d, predictor disagrees", $time, n);
                errors++;
            end
        end
        next_ts = prev_ts;

        drain();
        write_reg(CFG_PROC_NOISE, 32'd655);
        write_reg(CFG_MEAS_NOISE, 32'd3277);
        random_phase(RANDOM_PER_PHASE);

        drain();
        send_idle_pct = 45;
        recv_idle_pct = 12;
        write_reg(CFG_PROC_NOISE, 32'h7fff_ffff);
        write_reg(CFG_MEAS_NOISE, 32'hffff_ffff);
        write_reg(CFG_START_POS_X, $urandom());
        random_phase(RANDOM_PER_PHASE);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_PROC_NOISE, $urandom_range(4096));
        write_reg(CFG_MEAS_NOISE, $urandom_range(65536, 1));
        random_phase(RANDOM_PER_PHASE);

        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
